/* src/nsqm_pkg.sv */
// Shared types and constants for the named stack/queue manager.
`default_nettype none

package nsqm_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int DEF_LIST_SLOTS = 16;
  localparam int DEF_NODE_POOL  = 256;
  localparam int DEF_VALUE_BITS = 32;

  // Fixed field widths
  localparam int KEY_W      = 16;
  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W   = 3;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_POP    = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EXISTS     = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_POOL_FULL  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_PUSH_RD,
    S_PUSH_WR,
    S_POP_RD
  } state_t;

  // Update request from the sequencer to the slot table
  typedef struct packed {
    logic create;
    logic set_nonempty;
    logic clr_nonempty;
    logic set_head;
    logic set_tail;
  } slot_wr_t;

endpackage : nsqm_pkg

`default_nettype wire

/* src/nsqm_node_mem.sv */
// Shared node pool: value and link memories, one write and one registered read each.
`default_nettype none

module nsqm_node_mem
  import nsqm_pkg::*;
#(
  parameter int NODE_POOL  = DEF_NODE_POOL,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int NW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1
) (
  input  wire logic                  clk,
  input  wire logic [NW-1:0]         rd_addr,
  output logic      [VALUE_BITS-1:0] rd_value,
  output logic      [NW-1:0]         rd_link,
  input  wire logic                  val_we,
  input  wire logic [NW-1:0]         val_addr,
  input  wire logic [VALUE_BITS-1:0] val_data,
  input  wire logic                  link_we,
  input  wire logic [NW-1:0]         link_addr,
  input  wire logic [NW-1:0]         link_data
);

  logic [VALUE_BITS-1:0] value_mem [NODE_POOL];
  logic [NW-1:0]         link_mem  [NODE_POOL];

  // Value store
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_addr] <= val_data;
    end
    rd_value <= value_mem[rd_addr];
  end

  // Link store
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_addr] <= link_data;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule : nsqm_node_mem

`default_nettype wire

/* src/nsqm_slot_table.sv */
// List descriptor table with the shared key comparator used by the scan.
`default_nettype none

module nsqm_slot_table
  import nsqm_pkg::*;
#(
  parameter int LIST_SLOTS = DEF_LIST_SLOTS,
  parameter int NODE_POOL  = DEF_NODE_POOL,
  localparam int SW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1,
  localparam int NW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // read / compare side
  input  wire logic [SW-1:0]    rd_idx,
  input  wire logic [KEY_W-1:0] cmp_key,
  output logic                  rd_match,
  output logic                  rd_used,
  output logic                  rd_is_queue,
  output logic                  rd_nonempty,
  output logic      [NW-1:0]    rd_head,
  output logic      [NW-1:0]    rd_tail,
  // update side
  input  wire slot_wr_t         wr_ctl,
  input  wire logic [SW-1:0]    wr_idx,
  input  wire logic             wr_is_queue,
  input  wire logic [NW-1:0]    wr_head,
  input  wire logic [NW-1:0]    wr_tail
);

  logic [LIST_SLOTS-1:0] used_r;
  logic [LIST_SLOTS-1:0] nonempty_r;
  logic [KEY_W-1:0]      key_r     [LIST_SLOTS];
  logic                  is_queue_r[LIST_SLOTS];
  logic [NW-1:0]         head_r    [LIST_SLOTS];
  logic [NW-1:0]         tail_r    [LIST_SLOTS];

  // Single comparator shared across the scan
  assign rd_used     = used_r[rd_idx];
  assign rd_nonempty = nonempty_r[rd_idx];
  assign rd_is_queue = is_queue_r[rd_idx];
  assign rd_head     = head_r[rd_idx];
  assign rd_tail     = tail_r[rd_idx];
  assign rd_match    = used_r[rd_idx] && (key_r[rd_idx] == cmp_key);

  // Occupancy flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      nonempty_r <= '0;
    end else begin
      if (wr_ctl.create) begin
        used_r[wr_idx]     <= 1'b1;
        nonempty_r[wr_idx] <= 1'b0;
      end else if (wr_ctl.set_nonempty) begin
        nonempty_r[wr_idx] <= 1'b1;
      end else if (wr_ctl.clr_nonempty) begin
        nonempty_r[wr_idx] <= 1'b0;
      end
    end
  end

  // Descriptor payload, only meaningful once written
  always_ff @(posedge clk) begin
    if (wr_ctl.create) begin
      key_r[wr_idx]      <= cmp_key;
      is_queue_r[wr_idx] <= wr_is_queue;
    end
    if (wr_ctl.set_head) begin
      head_r[wr_idx] <= wr_head;
    end
    if (wr_ctl.set_tail) begin
      tail_r[wr_idx] <= wr_tail;
    end
  end

endmodule : nsqm_slot_table

`default_nettype wire

/* src/named_stack_queue_manager.sv */
// Top level: command sequencer over the slot table and the shared node pool.
// After the scan, create, unknown names and errors finish in S_EXEC; pop adds S_POP_RD,
// push of a never-used node adds S_PUSH_WR, and push of a recycled node adds S_PUSH_RD
// then S_PUSH_WR. The key scan compares one slot per cycle and stops on the matching
// slot, or on slot LIST_SLOTS-1 when no slot matches; busy is high from acceptance
// until the strobe cycle, and the next transaction is taken at the edge that ends the
// strobe. Reset is synchronous: empty table, empty pool.
`default_nettype none

module named_stack_queue_manager
  import nsqm_pkg::*;
#(
  parameter int LIST_SLOTS = DEF_LIST_SLOTS,
  parameter int NODE_POOL  = DEF_NODE_POOL,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_action,
  input  wire logic [KEY_W-1:0]      in_list_key,
  input  wire logic                  in_list_kind,
  input  wire logic [IN_VALUE_W-1:0] in_value,
  output logic                       out_valid,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [IN_VALUE_W-1:0] out_popped_value,
  output logic                       out_popped_valid
);

  localparam int SW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int NW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(LIST_SLOTS - 1);
  localparam logic [NW:0]   POOL_SIZE = (NW + 1)'(NODE_POOL);

  // Control and transaction registers
  state_t                  state_r, state_nxt;
  logic [SW-1:0]           sc_r, sc_nxt;
  logic [SW-1:0]           free_r, free_nxt;
  logic                    found_r, found_nxt;
  logic                    free_ok_r, free_ok_nxt;
  action_t                 act_r;
  logic [KEY_W-1:0]        key_r;
  logic                    kind_r;
  logic [VALUE_BITS-1:0]   entry_r;
  logic [NW-1:0]           node_r, node_nxt;
  logic [NW-1:0]           rhead_r, rhead_nxt;
  logic [NW:0]             rcount_r, rcount_nxt;
  logic [NW:0]             fresh_r, fresh_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [IN_VALUE_W-1:0]   out_pval_r, out_pval_nxt;
  logic                    out_pvalid_r, out_pvalid_nxt;

  // Sub-block connections
  logic                    st_match, st_used, st_is_queue, st_nonempty;
  logic [NW-1:0]           st_head, st_tail;
  slot_wr_t                st_wr;
  logic [SW-1:0]           st_wr_idx;
  logic [NW-1:0]           st_wr_head, st_wr_tail;
  logic [NW-1:0]           mem_rd_addr;
  logic [VALUE_BITS-1:0]   mem_rd_value;
  logic [NW-1:0]           mem_rd_link;
  logic                    mem_val_we, mem_link_we;
  logic [NW-1:0]           mem_link_addr, mem_link_data;
  logic                    accept;
  logic [VALUE_BITS-1:0]   in_entry;
  logic [IN_VALUE_W-1:0]   pop_word;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Sign-extend or truncate the pushed value to the stored width, and back out
  if (VALUE_BITS > IN_VALUE_W) begin : g_wide
    assign in_entry = {{(VALUE_BITS - IN_VALUE_W){in_value[IN_VALUE_W-1]}}, in_value};
    assign pop_word = mem_rd_value[IN_VALUE_W-1:0];
  end else if (VALUE_BITS == IN_VALUE_W) begin : g_same
    assign in_entry = in_value;
    assign pop_word = mem_rd_value;
  end else begin : g_narrow
    assign in_entry = in_value[VALUE_BITS-1:0];
    assign pop_word = {{(IN_VALUE_W - VALUE_BITS){1'b0}}, mem_rd_value};
  end

  nsqm_slot_table #(
    .LIST_SLOTS (LIST_SLOTS),
    .NODE_POOL  (NODE_POOL)
  ) u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_idx      (sc_r),
    .cmp_key     (key_r),
    .rd_match    (st_match),
    .rd_used     (st_used),
    .rd_is_queue (st_is_queue),
    .rd_nonempty (st_nonempty),
    .rd_head     (st_head),
    .rd_tail     (st_tail),
    .wr_ctl      (st_wr),
    .wr_idx      (st_wr_idx),
    .wr_is_queue (kind_r),
    .wr_head     (st_wr_head),
    .wr_tail     (st_wr_tail)
  );

  nsqm_node_mem #(
    .NODE_POOL  (NODE_POOL),
    .VALUE_BITS (VALUE_BITS)
  ) u_nodes (
    .clk       (clk),
    .rd_addr   (mem_rd_addr),
    .rd_value  (mem_rd_value),
    .rd_link   (mem_rd_link),
    .val_we    (mem_val_we),
    .val_addr  (node_r),
    .val_data  (entry_r),
    .link_we   (mem_link_we),
    .link_addr (mem_link_addr),
    .link_data (mem_link_data)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rhead_r      <= '0;
      rcount_r     <= '0;
      fresh_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rhead_r      <= rhead_nxt;
      rcount_r     <= rcount_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Transaction payload and scan bookkeeping
  always_ff @(posedge clk) begin
    sc_r         <= sc_nxt;
    free_r       <= free_nxt;
    found_r      <= found_nxt;
    free_ok_r    <= free_ok_nxt;
    node_r       <= node_nxt;
    out_status_r <= out_status_nxt;
    out_pval_r   <= out_pval_nxt;
    out_pvalid_r <= out_pvalid_nxt;
    if (accept) begin
      act_r   <= action_t'(in_action);
      key_r   <= in_list_key;
      kind_r  <= in_list_kind;
      entry_r <= in_entry;
    end
  end

  // Sequencer: next state, table and pool updates
  always_comb begin
    state_nxt      = state_r;
    sc_nxt         = sc_r;
    free_nxt       = free_r;
    found_nxt      = found_r;
    free_ok_nxt    = free_ok_r;
    node_nxt       = node_r;
    rhead_nxt      = rhead_r;
    rcount_nxt     = rcount_r;
    fresh_nxt      = fresh_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pval_nxt   = out_pval_r;
    out_pvalid_nxt = out_pvalid_r;
    st_wr          = '0;
    st_wr_idx      = sc_r;
    st_wr_head     = node_r;
    st_wr_tail     = node_r;
    mem_rd_addr    = rhead_r;
    mem_val_we     = 1'b0;
    mem_link_we    = 1'b0;
    mem_link_addr  = node_r;
    mem_link_data  = rhead_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          sc_nxt      = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end

      // One slot per cycle; stops on the first match
      S_SCAN: begin
        if (!st_used && !free_ok_r) begin
          free_nxt    = sc_r;
          free_ok_nxt = 1'b1;
        end
        if (st_match) begin
          found_nxt = 1'b1;
          state_nxt = S_EXEC;
        end else if (sc_r == LAST_SLOT) begin
          state_nxt = S_EXEC;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end

      S_EXEC: begin
        out_pval_nxt   = '0;
        out_pvalid_nxt = 1'b0;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        case (act_r)
          ACT_CREATE: begin
            if (found_r) begin
              out_status_nxt = ST_EXISTS;
            end else if (!free_ok_r) begin
              out_status_nxt = ST_TABLE_FULL;
            end else begin
              st_wr.create = 1'b1;
              st_wr_idx    = free_r;
            end
          end
          ACT_PUSH: begin
            if (!found_r) begin
              out_status_nxt = ST_UNKNOWN;
            end else if (rcount_r != '0) begin
              // recycled chain first; fetch its successor
              node_nxt      = rhead_r;
              mem_rd_addr   = rhead_r;
              out_valid_nxt = 1'b0;
              state_nxt     = S_PUSH_RD;
            end else if (fresh_r < POOL_SIZE) begin
              node_nxt      = fresh_r[NW-1:0];
              fresh_nxt     = fresh_r + 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = S_PUSH_WR;
            end else begin
              out_status_nxt = ST_POOL_FULL;
            end
          end
          ACT_POP: begin
            if (!found_r) begin
              out_status_nxt = ST_UNKNOWN;
            end else if (!st_nonempty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              node_nxt      = st_head;
              mem_rd_addr   = st_head;
              out_valid_nxt = 1'b0;
              state_nxt     = S_POP_RD;
            end
          end
          default: begin
          end
        endcase
      end

      // Unlink the recycled node taken for this push
      S_PUSH_RD: begin
        rhead_nxt  = mem_rd_link;
        rcount_nxt = rcount_r - 1'b1;
        state_nxt  = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        mem_val_we         = 1'b1;
        st_wr.set_nonempty = 1'b1;
        if (st_is_queue) begin
          if (st_nonempty) begin
            mem_link_we   = 1'b1;
            mem_link_addr = st_tail;
            mem_link_data = node_r;
          end else begin
            st_wr.set_head = 1'b1;
          end
          st_wr.set_tail = 1'b1;
        end else begin
          mem_link_we   = 1'b1;
          mem_link_addr = node_r;
          mem_link_data = st_head;
          if (!st_nonempty) begin
            st_wr.set_tail = 1'b1;
          end
          st_wr.set_head = 1'b1;
        end
        out_status_nxt = ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      // Head node data is back: advance the list, recycle the node
      S_POP_RD: begin
        if (st_head == st_tail) begin
          st_wr.clr_nonempty = 1'b1;
        end else begin
          st_wr.set_head = 1'b1;
          st_wr_head     = mem_rd_link;
        end
        mem_link_we    = 1'b1;
        mem_link_addr  = node_r;
        mem_link_data  = rhead_r;
        rhead_nxt      = node_r;
        rcount_nxt     = rcount_r + 1'b1;
        out_status_nxt = ST_OK;
        out_pval_nxt   = pop_word;
        out_pvalid_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_pval_r;
  assign out_popped_valid = out_pvalid_r;

  // Result strobe coincides with the sequencer being ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  // A popped entry only comes with an ok status
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pvalid_r) |-> (out_status_r == ST_OK))
    else $error("popped entry with error status");

  // Recycled nodes can never outnumber nodes ever handed out
  a_pool_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rcount_r <= fresh_r) && (fresh_r <= POOL_SIZE))
    else $error("node pool accounting broken");

  // An accepted command is held busy, with no stale result strobe, as the sequencer leaves idle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid_r))
    else $error("command not held busy after acceptance");

endmodule : named_stack_queue_manager

`default_nettype wire

/* test/named_stack_queue_manager_test.sv */
// Self-checking testbench for the named stack/queue manager: directed and random commands.
`timescale 1ns / 1ps

module named_stack_queue_manager_test;
  import nsqm_pkg::*;

  localparam int LIST_SLOTS   = DEF_LIST_SLOTS;
  localparam int NODE_POOL    = DEF_NODE_POOL;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 2 * LIST_SLOTS + 8;
  localparam int RANDOM_ITEMS = 780;
  // Action code with no meaning: the block must leave its state alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    status_t               status;
    logic [IN_VALUE_W-1:0] popped_value;
    logic                  popped_valid;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_action;
  logic [KEY_W-1:0]      in_list_key;
  logic                  in_list_kind;
  logic [IN_VALUE_W-1:0] in_value;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [IN_VALUE_W-1:0] out_popped_value;
  logic                  out_popped_valid;

  // Expected replies, oldest first
  reply_t reply_q[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     burst_left  = 0;

  // Shadow of the list table and node pool
  bit                  slot_used[LIST_SLOTS];
  bit [KEY_W-1:0]      slot_key[LIST_SLOTS];
  bit                  slot_is_queue[LIST_SLOTS];
  bit                  slot_nonempty[LIST_SLOTS];
  int                  slot_head[LIST_SLOTS];
  int                  slot_tail[LIST_SLOTS];
  bit [IN_VALUE_W-1:0] node_value[NODE_POOL];
  int                  node_link[NODE_POOL];
  int                  recycled_head  = 0;
  int                  recycled_count = 0;
  int                  fresh_next     = 0;

  // Names created by the tests; random traffic mostly targets these
  bit [KEY_W-1:0] known_keys[LIST_SLOTS];

  named_stack_queue_manager u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_list_key      (in_list_key),
    .in_list_kind     (in_list_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d replies outstanding", cycle_count, reply_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- shadow model

  function automatic int find_slot(input bit [KEY_W-1:0] key);
    for (int i = 0; i < LIST_SLOTS; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // Recycled nodes go first, then never-used ones
  function automatic bit take_node(output int idx);
    idx = 0;
    if (recycled_count > 0) begin
      idx = recycled_head;
      recycled_head = node_link[recycled_head];
      recycled_count--;
      return 1'b1;
    end
    if (fresh_next < NODE_POOL) begin
      idx = fresh_next;
      fresh_next++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reply_t apply_command(input logic [1:0] act, input logic [KEY_W-1:0] key,
                                           input logic kind, input logic [IN_VALUE_W-1:0] val);
    reply_t r;
    int     s;
    int     f;
    int     n;
    r.status       = ST_OK;
    r.popped_value = '0;
    r.popped_valid = 1'b0;
    s = find_slot(key);
    case (act)
      ACT_CREATE: begin
        if (s >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          f = -1;
          for (int i = 0; i < LIST_SLOTS; i++)
            if (!slot_used[i] && f < 0) f = i;
          if (f < 0) begin
            r.status = ST_TABLE_FULL;
          end else begin
            slot_used[f]     = 1'b1;
            slot_key[f]      = key;
            slot_is_queue[f] = kind;
            slot_nonempty[f] = 1'b0;
          end
        end
      end
      ACT_PUSH: begin
        if (s < 0) begin
          r.status = ST_UNKNOWN;
        end else if (!take_node(n)) begin
          r.status = ST_POOL_FULL;
        end else begin
          node_value[n] = val;
          if (slot_is_queue[s]) begin
            if (slot_nonempty[s]) node_link[slot_tail[s]] = n;
            else slot_head[s] = n;
            slot_tail[s] = n;
          end else begin
            node_link[n] = slot_head[s];
            if (!slot_nonempty[s]) slot_tail[s] = n;
            slot_head[s] = n;
          end
          slot_nonempty[s] = 1'b1;
        end
      end
      ACT_POP: begin
        if (s < 0) begin
          r.status = ST_UNKNOWN;
        end else if (!slot_nonempty[s]) begin
          r.status = ST_EMPTY;
        end else begin
          n = slot_head[s];
          r.popped_value = node_value[n];
          r.popped_valid = 1'b1;
          if (slot_head[s] == slot_tail[s]) slot_nonempty[s] = 1'b0;
          else slot_head[s] = node_link[n];
          // freed node goes to the front of the recycled chain
          node_link[n]  = recycled_head;
          recycled_head = n;
          recycled_count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  // Sends one command; the sender works in bursts separated by idle gaps
  task automatic send_command(input logic [1:0] act, input logic [KEY_W-1:0] key,
                              input logic kind, input logic [IN_VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    start        <= 1'b1;
    in_action    <= act;
    in_list_key  <= key;
    in_list_kind <= kind;
    in_value     <= val;
    do @(posedge clk); while (busy);
    reply_q.push_back(apply_command(act, key, kind, val));
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0h valid %0b",
                         out_status, out_popped_value, out_popped_valid));
      end else begin
        exp_r = reply_q.pop_front();
        if (out_status !== exp_r.status)
          report($sformatf("status got %0d expected %0d", out_status, exp_r.status));
        if (out_popped_value !== exp_r.popped_value)
          report($sformatf("popped_value got %0h expected %0h",
                           out_popped_value, exp_r.popped_value));
        if (out_popped_valid !== exp_r.popped_valid)
          report($sformatf("popped_valid got %0b expected %0b",
                           out_popped_valid, exp_r.popped_valid));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Extreme keys and values, every action, the error cases on a near-empty table
  task automatic test_basic_commands;
    known_keys[0] = 16'h0000;
    known_keys[1] = 16'hFFFF;
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);   // unknown name
    send_command(ACT_PUSH,   16'hFFFF, 1'b1, 32'hFFFF_FFFF);   // unknown name
    send_command(ACT_UNUSED, 16'hA5A5, 1'b1, 32'h5A5A_5A5A);   // no effect
    send_command(ACT_CREATE, 16'h0000, 1'b0, 32'h0000_0000);   // stack
    send_command(ACT_CREATE, 16'h0000, 1'b1, 32'h0000_0000);   // name exists
    send_command(ACT_CREATE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);   // queue
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);   // list empty
    send_command(ACT_PUSH,   16'h0000, 1'b0, 32'h7FFF_FFFF);
    send_command(ACT_PUSH,   16'h0000, 1'b1, 32'h8000_0000);
    send_command(ACT_PUSH,   16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    send_command(ACT_PUSH,   16'hFFFF, 1'b1, 32'h0000_0000);
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);   // last in, first out
    send_command(ACT_POP,    16'hFFFF, 1'b0, 32'h0000_0000);   // first in, first out
    send_command(ACT_POP,    16'hFFFF, 1'b0, 32'h0000_0000);
    send_command(ACT_POP,    16'hFFFF, 1'b0, 32'h0000_0000);   // queue now empty
    send_command(ACT_PUSH,   16'h0000, 1'b0, 32'h0000_0001);   // reuses a freed node
    send_command(ACT_PUSH,   16'hFFFF, 1'b1, 32'h1234_5678);   // and another
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);
    send_command(ACT_POP,    16'h0000, 1'b0, 32'h0000_0000);   // empty again
    send_command(ACT_UNUSED, 16'h0000, 1'b0, 32'h0000_0000);
  endtask

  // Fill every slot, then one create too many
  task automatic test_table_full;
    bit [KEY_W-1:0] key;
    for (int i = 2; i < LIST_SLOTS; i++) begin
      do key = KEY_W'($urandom_range(1, 16'hFFFE)); while (find_slot(key) >= 0);
      known_keys[i] = key;
      send_command(ACT_CREATE, key, 1'($urandom_range(0, 1)), $urandom());
    end
    do key = KEY_W'($urandom_range(1, 16'hFFFE)); while (find_slot(key) >= 0);
    send_command(ACT_CREATE, key, 1'b0, 32'h0000_0000);        // table full
    send_command(ACT_CREATE, known_keys[5], 1'b1, 32'h0000_0000);
    send_command(ACT_PUSH, key, 1'b0, 32'hDEAD_BEEF);          // never created
  endtask

  // Exhaust the node pool over a stack and a queue, then drain both
  task automatic test_pool_exhaustion;
    int free_nodes;
    free_nodes = NODE_POOL - fresh_next + recycled_count;
    for (int i = 0; i < free_nodes + 3; i++)
      send_command(ACT_PUSH, known_keys[i % 2], 1'($urandom_range(0, 1)), $urandom());
    for (int k = 0; k < 2; k++) begin
      while (slot_nonempty[find_slot(known_keys[k])])
        send_command(ACT_POP, known_keys[k], 1'($urandom_range(0, 1)), $urandom());
      send_command(ACT_POP, known_keys[k], 1'b0, 32'h0000_0000);
    end
  endtask

  // Random traffic; the push/pop balance drifts so list depths sweep up and down
  task automatic test_random_traffic;
    int             push_pct;
    int             pick;
    logic [1:0]     act;
    bit [KEY_W-1:0] key;
    logic [IN_VALUE_W-1:0] val;
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) push_pct = $urandom_range(15, 90);
      pick = $urandom_range(0, 99);
      if (pick < 4)      act = ACT_CREATE;
      else if (pick < 7) act = ACT_UNUSED;
      else if ($urandom_range(0, 99) < push_pct) act = ACT_PUSH;
      else act = ACT_POP;
      if ($urandom_range(0, 99) < 88) key = known_keys[$urandom_range(0, LIST_SLOTS - 1)];
      else key = KEY_W'($urandom_range(0, 16'hFFFF));
      case ($urandom_range(0, 9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0000_0000;
        default: val = $urandom();
      endcase
      send_command(act, key, 1'($urandom_range(0, 1)), val);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_CREATE;
    in_list_key  = '0;
    in_list_kind = 1'b0;
    in_value     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_table_full();
    test_pool_exhaustion();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    // the watchdog catches replies that never arrive
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
